// File: design/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, codes and the sine table builder for the radix-2 FFT block.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int CFG_W          = 4;
  localparam int IN_DATA_W      = 48;
  localparam int OUT_DATA_W     = 64;
  localparam logic [CFG_W-1:0] LOG2_RESET = 4'd10;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_READ = 1'b1;

  typedef enum logic [3:0] {
    BS_NONE,
    BS_RD,
    BS_M0,
    BS_M1,
    BS_M2,
    BS_M3,
    BS_M4,
    BS_W0,
    BS_W1
  } bf_step_t;

  typedef struct packed {
    logic     cfg_wr;
    logic     load;
    logic     xform_init;
    logic     read_req;
    logic     resp;
    bf_step_t step;
    logic     bf_next;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_load;
    logic bf_last;
    logic stage_last;
  } dp_status_t;

  // Quarter-wave sine entry in Q1.15 from a truncated Q30 Taylor series.
  function automatic logic [15:0] sine_entry(input int k, input int lg_max);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x   = (64'd6746518852 * 64'(k) + (64'd1 << (lg_max - 1))) >> lg_max;
    x2  = (x * x) >> 30;
    t   = x;
    sum = $signed(x);
    t   = ((t * x2) >> 30) / 64'd6;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd20;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd42;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd72;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd110;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd156;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd210;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd272;
    sum = sum + $signed(t);
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [33:0] round_q15(input logic signed [48:0] p);
    logic signed [48:0] q;
    q = p + 49'sd16384;
    return q[48:15];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v[34:31] != {4{v[34]}}) begin
      r = v[34] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: design/r2fft_dp.sv
// ----------------------------------------------------------------------------
// r2fft_dp
// Sample store, address generation, twiddle table, butterfly arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module r2fft_dp #(
  parameter int MAX_POINTS = r2fft_pkg::DEF_MAX_POINTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  r2fft_pkg::dp_cmd_t                 cmd,
  output r2fft_pkg::dp_status_t              status,
  input  logic [r2fft_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [r2fft_pkg::CFG_W-1:0]        cfg_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [r2fft_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                               m_tuser
);
  import r2fft_pkg::*;

  localparam int LG  = $clog2(MAX_POINTS);
  localparam int KW  = LG - 1;
  localparam int SW  = $clog2(LG);
  localparam int LGW = $clog2(LG + 1);
  localparam int Q   = MAX_POINTS / 4;

  logic [31:0] mem_re [MAX_POINTS];
  logic [31:0] mem_im [MAX_POINTS];

  logic signed [15:0] rom [Q+1];

  for (genvar g = 0; g <= Q; g++) begin : g_rom
    localparam logic [15:0] V = sine_entry(g, LG);
    assign rom[g] = V;
  end

  logic [CFG_W-1:0] lg_cfg;
  logic [LGW-1:0]   lg_eff;
  logic [LG-1:0]    n_mask;
  logic [LG-1:0]    count;
  logic [LG-1:0]    rev;
  logic [LG-1:0]    load_addr;
  logic             done;
  logic [SW-1:0]    stage;
  logic [KW-1:0]    k;
  logic [KW-1:0]    hm;
  logic [KW-1:0]    low;
  logic [KW-1:0]    high;
  logic [LG-1:0]    addr_i;
  logic [LG-1:0]    addr_ip;
  logic [KW-1:0]    tw;
  logic [KW-1:0]    s_idx;
  logic [KW-1:0]    c_idx;
  logic             c_neg;
  logic [LG-1:0]    rb_addr;
  logic [LG-1:0]    rd_addr;

  logic signed [31:0] ar;
  logic signed [31:0] ai;
  logic signed [31:0] br;
  logic signed [31:0] bi;
  logic signed [15:0] c_r;
  logic signed [15:0] s_r;
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [47:0] prod;
  logic signed [48:0] acc;
  logic signed [33:0] tr;
  logic signed [33:0] ti;

  logic             we;
  logic [LG-1:0]    wa;
  logic [31:0]      wd_re;
  logic [31:0]      wd_im;

  always_comb begin
    if (lg_cfg == '0) begin
      lg_eff = LGW'(1);
    end else if (32'(lg_cfg) > LG) begin
      lg_eff = LGW'(LG);
    end else begin
      lg_eff = LGW'(lg_cfg);
    end
    n_mask = {LG{1'b1}} >> (LG - 32'(lg_eff));
    for (int b = 0; b < LG; b++) begin
      rev[b] = count[LG-1-b];
    end
    load_addr = rev >> (LG - 32'(lg_eff));
    hm      = ~({KW{1'b1}} << stage);
    low     = k & hm;
    high    = k & ~hm;
    addr_i  = {high, 1'b0} | {1'b0, low};
    addr_ip = addr_i | (LG'(1) << stage);
    tw      = low << (KW - 32'(stage));
    if (tw <= KW'(Q)) begin
      s_idx = tw;
      c_idx = KW'(Q) - tw;
      c_neg = 1'b0;
    end else begin
      s_idx = -tw;
      c_idx = tw - KW'(Q);
      c_neg = 1'b1;
    end
    rb_addr = LG'(s_tdata[41:32]) & n_mask;
    rd_addr = cmd.read_req ? rb_addr : addr_i;
  end

  assign status.out_free   = !m_tvalid || m_tready;
  assign status.last_load  = (count == n_mask);
  assign status.bf_last    = (k == n_mask[LG-1:1]);
  assign status.stage_last = (LGW'(stage) == lg_eff - LGW'(1));

  always_comb begin
    case (cmd.step)
      BS_M0: begin
        mul_a = br;
        mul_b = c_r;
      end
      BS_M1: begin
        mul_a = bi;
        mul_b = s_r;
      end
      BS_M2: begin
        mul_a = bi;
        mul_b = c_r;
      end
      default: begin
        mul_a = br;
        mul_b = s_r;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wa    = load_addr;
    wd_re = {{16{s_tdata[15]}}, s_tdata[15:0]};
    wd_im = {{16{s_tdata[31]}}, s_tdata[31:16]};
    if (cmd.load) begin
      we = 1'b1;
    end else if (cmd.step == BS_W0) begin
      we    = 1'b1;
      wa    = addr_ip;
      wd_re = sat32(35'(ar) - 35'(tr));
      wd_im = sat32(35'(ai) - 35'(ti));
    end else if (cmd.step == BS_W1) begin
      we    = 1'b1;
      wa    = addr_i;
      wd_re = sat32(35'(ar) + 35'(tr));
      wd_im = sat32(35'(ai) + 35'(ti));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_re[wa] <= wd_re;
      mem_im[wa] <= wd_im;
    end
    if (cmd.read_req || cmd.step == BS_RD) begin
      ar <= mem_re[rd_addr];
      ai <= mem_im[rd_addr];
      br <= mem_re[addr_ip];
      bi <= mem_im[addr_ip];
    end
    if (cmd.step == BS_RD) begin
      s_r <= rom[s_idx];
      c_r <= c_neg ? -rom[c_idx] : rom[c_idx];
    end
    prod <= 48'(mul_a * mul_b);
    case (cmd.step)
      BS_M1:   acc <= 49'(prod);
      BS_M2:   tr  <= round_q15(acc + 49'(prod));
      BS_M3:   acc <= 49'(prod);
      BS_M4:   ti  <= round_q15(acc - 49'(prod));
      default: acc <= acc;
    endcase
    if (cmd.resp) begin
      m_tdata <= done ? {ai, ar} : '0;
      m_tuser <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_cfg   <= LOG2_RESET;
      count    <= '0;
      done     <= 1'b0;
      stage    <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        lg_cfg <= cfg_data;
        count  <= '0;
        done   <= 1'b0;
      end else if (cmd.load) begin
        done  <= 1'b0;
        count <= status.last_load ? '0 : count + LG'(1);
      end
      if (cmd.xform_init) begin
        stage <= '0;
        k     <= '0;
      end else if (cmd.bf_next) begin
        if (status.bf_last) begin
          k     <= '0;
          stage <= stage + SW'(1);
          if (status.stage_last) begin
            done <= 1'b1;
          end
        end else begin
          k <= k + KW'(1);
        end
      end
      if (cmd.resp) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// File: design/r2fft_ctrl.sv
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Controller that takes items and sequences each butterfly of the transform.
// ----------------------------------------------------------------------------
module r2fft_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  r2fft_pkg::dp_status_t status,
  output r2fft_pkg::dp_cmd_t    cmd
);
  import r2fft_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_RESP = 10'b00_0000_0010,
    ST_RD   = 10'b00_0000_0100,
    ST_M0   = 10'b00_0000_1000,
    ST_M1   = 10'b00_0001_0000,
    ST_M2   = 10'b00_0010_0000,
    ST_M3   = 10'b00_0100_0000,
    ST_M4   = 10'b00_1000_0000,
    ST_W0   = 10'b01_0000_0000,
    ST_W1   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign cfg_ready = (state == ST_IDLE);
  assign s_tready  = (state == ST_IDLE) && status.out_free && !cfg_valid;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.step       = BS_NONE;
    cmd.cfg_wr     = cfg_valid && cfg_ready;
    case (state)
      ST_IDLE: begin
        if (accept && !cfg_valid) begin
          if (s_tuser == OPC_LOAD) begin
            cmd.load = 1'b1;
            if (status.last_load) begin
              cmd.xform_init = 1'b1;
              state_next     = ST_RD;
            end
          end else begin
            cmd.read_req = 1'b1;
            state_next   = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        cmd.resp   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD: begin
        cmd.step   = BS_RD;
        state_next = ST_M0;
      end
      ST_M0: begin
        cmd.step   = BS_M0;
        state_next = ST_M1;
      end
      ST_M1: begin
        cmd.step   = BS_M1;
        state_next = ST_M2;
      end
      ST_M2: begin
        cmd.step   = BS_M2;
        state_next = ST_M3;
      end
      ST_M3: begin
        cmd.step   = BS_M3;
        state_next = ST_M4;
      end
      ST_M4: begin
        cmd.step   = BS_M4;
        state_next = ST_W0;
      end
      ST_W0: begin
        cmd.step   = BS_W0;
        state_next = ST_W1;
      end
      ST_W1: begin
        cmd.step    = BS_W1;
        cmd.bf_next = 1'b1;
        state_next  = (status.bf_last && status.stage_last) ? ST_IDLE : ST_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/radix2_complex_fft.sv
// ----------------------------------------------------------------------------
// radix2_complex_fft
// Forward in-place radix-2 complex FFT with a load and read item stream.
// ----------------------------------------------------------------------------
// Load items are stored in bit-reversed order. The load that completes a
// batch of N points starts the transform, during which no item is taken: it
// runs (N/2)*log2(N) butterflies, and every butterfly reads both operands,
// forms four products through one shared multiplier and writes its two
// results through the single write port. A read item passes through the
// response state and yields one registered result item.
module radix2_complex_fft #(
  parameter int MAX_POINTS = r2fft_pkg::DEF_MAX_POINTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample_re[15:0], sample_im[31:16], read_bin[41:32], zero fill above
  input  logic [r2fft_pkg::IN_DATA_W-1:0]  s_tdata,
  // opcode
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // bin_re[31:0], bin_im[63:32]
  output logic [r2fft_pkg::OUT_DATA_W-1:0] m_tdata,
  // ready_res
  output logic                             m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [r2fft_pkg::CFG_W-1:0]      cfg_data
);
  import r2fft_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  r2fft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .status   (status),
    .cmd      (cmd)
  );

  r2fft_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == OPC_READ, 2))
    else $error("Result item without a read item.");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("Bin data not zero while transform is not done.");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (cmd.step != BS_NONE) |-> !s_tready)
    else $error("Item taken during the transform.");

endmodule
